### rtl/crc24_pkg.sv
// Shared types, constants and the word fold function for the CRC-24 word pair stream.
package crc24_pkg;

  localparam int unsigned CrcWidth  = 24;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned WordWidth = 16;

  localparam logic [CrcWidth-1:0] CrcPoly = 24'h80001B;
  localparam logic [CrcWidth-1:0] CrcInit = 24'h000000;

  // One input request as it travels from the input register to the fold stage
  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 last;
  } crc24_req_t;

  // Fold one 16-bit word into the running checksum
  function automatic logic [CrcWidth-1:0] crc24_fold(input logic [CrcWidth-1:0]  crc,
                                                     input logic [WordWidth-1:0] word);
    logic [CrcWidth-1:0] next;
    next = {crc[CrcWidth-2:0], 1'b0} ^ {{(CrcWidth-WordWidth){1'b0}}, word};
    if (crc[CrcWidth-1]) begin
      next = next ^ CrcPoly;
    end
    return next;
  endfunction

endpackage

### rtl/crc24_fold.sv
// Fold stage: byte pairing, checksum state and the result register.
module crc24_fold import crc24_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  crc24_req_t          req_i,
  output logic                req_ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CrcWidth-1:0] checksum_o
);

  logic [CrcWidth-1:0]  crc_q, crc_d;
  logic [ByteWidth-1:0] held_q, held_d;
  logic                 have_q, have_d;
  logic                 out_valid_q, out_valid_d;
  logic [CrcWidth-1:0]  checksum_q, checksum_d;
  logic                 take;
  logic [CrcWidth-1:0]  crc_new;

  // Take a non-final byte at once; hold a final byte until the result register is free
  assign req_ready_o = !req_i.last || !out_valid_q || !out_stall_i;
  assign take        = req_valid_i && req_ready_o;

  // Fold the completed word: a held pair, or a lone final byte with zero high half
  always_comb begin
    if (have_q) begin
      crc_new = crc24_fold(crc_q, {req_i.data_byte, held_q});
    end else begin
      crc_new = crc24_fold(crc_q, {{(WordWidth-ByteWidth){1'b0}}, req_i.data_byte});
    end
  end

  // Advance the checksum state
  always_comb begin
    crc_d  = crc_q;
    held_d = held_q;
    have_d = have_q;
    if (take) begin
      if (req_i.last) begin
        crc_d  = CrcInit;
        held_d = '0;
        have_d = 1'b0;
      end else if (have_q) begin
        crc_d  = crc_new;
        held_d = '0;
        have_d = 1'b0;
      end else begin
        held_d = req_i.data_byte;
        have_d = 1'b1;
      end
    end
  end

  // Load the result register on a final byte, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    checksum_d  = checksum_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (take && req_i.last) begin
      out_valid_d = 1'b1;
      checksum_d  = crc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      held_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      held_q      <= held_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload without reset
  always_ff @(posedge clk_i) begin
    checksum_q <= checksum_d;
  end

  assign out_valid_o = out_valid_q;
  assign checksum_o  = checksum_q;

endmodule

### rtl/crc24_word_pair_stream.sv
// Top level of the CRC-24 word pair stream: input register and fold stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o, data_byte_i, last_i) takes one
//   message byte per request; last_i marks the final byte of a message.
//   Bytes pair little-endian into 16-bit words that fold into a 24-bit
//   checksum (polynomial 0x80001B). An odd final byte pairs with zero.
//   Output channel (out_valid_o / out_stall_i, checksum_o) carries one
//   request per message: the checksum, after which the state is zero again.
// Timing:
//   Throughput is one byte per cycle while in_stall_o is low; every fold is
//   a single shift and XOR between the input register and the result register.
//   From acceptance of the final byte, checksum_o becomes valid after the
//   input register, then the result register.
// Reset:
//   rst_ni clears the running checksum, the held byte and both valid flags.
// Stall:
//   A stalled result holds checksum_o steady. The fold stage keeps taking
//   bytes while the result waits; only an item that would load a new
//   result waits in the input register, and in_stall_o rises once that
//   register is full and cannot drain.
module crc24_word_pair_stream import crc24_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ByteWidth-1:0] data_byte_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CrcWidth-1:0]  checksum_o
);

  logic       in_valid_q, in_valid_d;
  crc24_req_t req_q, req_d;
  logic       fold_ready;
  logic       fold_block;
  logic       in_take;

  // A byte that completes no result never needs the result register
  assign fold_block = in_valid_q && req_q.last && !fold_ready;
  assign in_stall_o = fold_block;
  assign in_take    = in_valid_i && !in_stall_o;

  // Advance the input register
  always_comb begin
    in_valid_d = in_valid_q;
    req_d      = req_q;
    if (!fold_block) begin
      in_valid_d = in_take;
    end
    if (in_take) begin
      req_d.data_byte = data_byte_i;
      req_d.last      = last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  crc24_fold u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_q && !fold_block),
    .req_i       (req_q),
    .req_ready_o (fold_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .checksum_o  (checksum_o)
  );

endmodule

### rtl/crc24_checker.sv
// Port-level checker for the CRC-24 word pair stream, bound to the top level.
module crc24_checker import crc24_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 last_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [CrcWidth-1:0]  checksum_o
);

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(checksum_o))
    else $error("checksum changed while stalled");

  // A taken final byte shows up as a valid result
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && last_i |=> ##1 out_valid_o)
    else $error("no result after final byte");

  // A new result comes only from a final byte taken at the input
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_take && last_i, 2))
    else $error("result without a final byte");

  // Only a waiting result can stall the input
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no result waiting");

endmodule

bind crc24_word_pair_stream crc24_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .checksum_o  (checksum_o)
);
